[hdl/multichannel_biquad_filter_macros.svh]
// Assertion macros used by the multichannel biquad filter port checker.
`ifndef MULTICHANNEL_BIQUAD_FILTER_MACROS_SVH
`define MULTICHANNEL_BIQUAD_FILTER_MACROS_SVH

// A stalled word stays valid and keeps its payload.
`define BQF_ASSERT_HOLD(label, vld, stl, payload) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(payload))) \
    else $error("stalled output word dropped or changed");

// A word for a channel still in flight must wait for its history write-back.
`define BQF_ASSERT_SAME_CH_WAIT(label, dly) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (in_valid && !in_stall) ## dly (in_valid && channel == $past(channel, dly)) \
        |-> in_stall) \
    else $error("same-channel word accepted before history write-back");

`endif

[hdl/bqf_pkg.sv]
// Shared constants and types of the multichannel biquad filter.
`timescale 1ns / 1ps

package bqf_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 24;
    localparam int COEF_FRAC    = 20;
    localparam int CH_BITS      = 3;
    localparam int CHANNELS     = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS     = PROD_BITS + 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = CFG_IDX_BITS'(4);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [CH_BITS-1:0]            chan_t;

    // unity gain in Q4.20
    localparam coef_t B0_RESET = COEF_BITS'(1 << COEF_FRAC);

    // per-channel history entry
    typedef struct packed {
        sample_t x1;
        sample_t x2;
        sample_t y1;
        sample_t y2;
    } hist_t;

endpackage

[hdl/multichannel_biquad_filter.sv]
// Top level of the multichannel biquad (direct form I) filter.
`timescale 1ns / 1ps

// Multichannel biquad filter. Each input word carries one Q1.23 sample and
// its channel number; the block returns y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
// for that channel, rounded half up to Q1.23 and saturated, with channel and
// block_end copied along. Coefficients are Q4.20 registers, pre-divided by a0.
// Rate: one word per cycle while out_stall is low and a word's channel differs
// from the channels of the three words before it that are still in the pipe. A
// word whose channel matches one in flight is held (in_stall high) until that
// word writes its history back, later for as long as out_stall holds the pipe;
// this is the read-modify-write loop through the history memory. A word passes
// s1 (memory read), s2 (multiply) and s3 (sum); round/saturate feeds the output
// register. Up to four words sit in the pipe, so input can still be taken while
// a result waits at the output, until s1 to s3 are full. History reset is
// immediate (written bits), no clearing pass.
// Write coefficients only while the block is idle.

module multichannel_biquad_filter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration
    input  logic                                     cfg_wen,
    input  logic [bqf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [bqf_pkg::COEF_BITS-1:0]            cfg_data,
    // input words
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [bqf_pkg::SAMPLE_BITS-1:0]   sample_in,
    input  logic [bqf_pkg::CH_BITS-1:0]              channel,
    input  logic                                     block_end,
    // output words
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [bqf_pkg::SAMPLE_BITS-1:0]   sample_out,
    output logic [bqf_pkg::CH_BITS-1:0]              channel_out,
    output logic                                     block_end_out
);

    localparam bqf_pkg::acc_t ROUND_HALF =
        bqf_pkg::ACC_BITS'(1 << (bqf_pkg::COEF_FRAC - 1));
    localparam bqf_pkg::acc_t SAT_HI =
        bqf_pkg::ACC_BITS'((1 << (bqf_pkg::SAMPLE_BITS - 1)) - 1);
    localparam bqf_pkg::acc_t SAT_LO = -SAT_HI - bqf_pkg::ACC_BITS'(1);

    // ---------------- coefficients ----------------
    bqf_pkg::coef_t coef_b0_reg;
    bqf_pkg::coef_t coef_b1_reg;
    bqf_pkg::coef_t coef_b2_reg;
    bqf_pkg::coef_t coef_a1_reg;
    bqf_pkg::coef_t coef_a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= bqf_pkg::B0_RESET;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                bqf_pkg::REG_B0: coef_b0_reg <= cfg_data;
                bqf_pkg::REG_B1: coef_b1_reg <= cfg_data;
                bqf_pkg::REG_B2: coef_b2_reg <= cfg_data;
                bqf_pkg::REG_A1: coef_a1_reg <= cfg_data;
                bqf_pkg::REG_A2: coef_a2_reg <= cfg_data;
                default: ;   // indexes past the list are ignored
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    // s1: history read in flight
    logic                 s1_valid_reg;
    bqf_pkg::sample_t     s1_x_reg;
    bqf_pkg::chan_t       s1_ch_reg;
    logic                 s1_be_reg;
    logic                 s1_ok_reg;
    // s2: products
    logic                 s2_valid_reg;
    bqf_pkg::prod_t       s2_prod_reg [5];
    bqf_pkg::sample_t     s2_x_reg;
    bqf_pkg::sample_t     s2_x1_reg;
    bqf_pkg::sample_t     s2_y1_reg;
    bqf_pkg::chan_t       s2_ch_reg;
    logic                 s2_be_reg;
    logic                 s2_ok_reg;
    // s3: sum with rounding bias
    logic                 s3_valid_reg;
    bqf_pkg::acc_t        s3_acc_reg;
    bqf_pkg::sample_t     s3_x_reg;
    bqf_pkg::sample_t     s3_x1_reg;
    bqf_pkg::sample_t     s3_y1_reg;
    bqf_pkg::chan_t       s3_ch_reg;
    logic                 s3_be_reg;
    logic                 s3_ok_reg;
    // output register
    logic                 out_valid_reg;
    bqf_pkg::sample_t     sample_out_reg;
    bqf_pkg::chan_t       channel_out_reg;
    logic                 block_end_out_reg;

    // ---------------- flow control ----------------
    // each stage moves when the next one is empty or moving
    logic en3;
    logic en2;
    logic en1;
    logic s1_free;
    logic hazard;
    logic in_accept;

    assign en3     = !out_valid_reg || !out_stall;
    assign en2     = !s3_valid_reg || en3;
    assign en1     = !s2_valid_reg || en2;
    assign s1_free = !s1_valid_reg || en1;

    // interlock: the history of a channel in s1..s3 is not written back yet
    assign hazard = (s1_valid_reg && (s1_ch_reg == channel))
                 || (s2_valid_reg && (s2_ch_reg == channel))
                 || (s3_valid_reg && (s3_ch_reg == channel));

    assign in_accept = in_valid && s1_free && !hazard;
    assign in_stall  = !(s1_free && !hazard);

    // ---------------- history memory ----------------
    bqf_pkg::hist_t hist_rd;
    bqf_pkg::hist_t hist_wr;
    logic           hist_wen;
    bqf_pkg::sample_t y_sat;

    assign hist_wen = en3 && s3_valid_reg && s3_ok_reg;
    assign hist_wr  = '{x1: s3_x_reg, x2: s3_x1_reg, y1: y_sat, y2: s3_y1_reg};

    bqf_hist_mem u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (channel),
        .rd_data (hist_rd),
        .wr_en   (hist_wen),
        .wr_addr (s3_ch_reg),
        .wr_data (hist_wr)
    );

    // ---------------- datapath ----------------
    logic            ch_ok;
    bqf_pkg::prod_t  prod [5];
    bqf_pkg::acc_t   acc_sum;
    bqf_pkg::acc_t   acc_shift;
    bqf_pkg::sample_t y_word;

    assign ch_ok = {1'b0, channel} < (bqf_pkg::CH_BITS + 1)'(bqf_pkg::CHANNELS);

    // five independent 24x24 multiplies, registered into s2
    assign prod[0] = bqf_pkg::prod_t'(coef_b0_reg) * bqf_pkg::prod_t'(s1_x_reg);
    assign prod[1] = bqf_pkg::prod_t'(coef_b1_reg) * bqf_pkg::prod_t'(hist_rd.x1);
    assign prod[2] = bqf_pkg::prod_t'(coef_b2_reg) * bqf_pkg::prod_t'(hist_rd.x2);
    assign prod[3] = bqf_pkg::prod_t'(coef_a1_reg) * bqf_pkg::prod_t'(hist_rd.y1);
    assign prod[4] = bqf_pkg::prod_t'(coef_a2_reg) * bqf_pkg::prod_t'(hist_rd.y2);

    // exact Q8.43 sum plus rounding bias
    assign acc_sum = bqf_pkg::acc_t'(s2_prod_reg[0])
                   + bqf_pkg::acc_t'(s2_prod_reg[1])
                   + bqf_pkg::acc_t'(s2_prod_reg[2])
                   - bqf_pkg::acc_t'(s2_prod_reg[3])
                   - bqf_pkg::acc_t'(s2_prod_reg[4])
                   + ROUND_HALF;

    // floor shift back to the sample format, then clamp
    assign acc_shift = s3_acc_reg >>> bqf_pkg::COEF_FRAC;

    always_comb
    begin
        if (acc_shift > SAT_HI)
        begin
            y_sat = bqf_pkg::sample_t'(SAT_HI[bqf_pkg::SAMPLE_BITS-1:0]);
        end
        else if (acc_shift < SAT_LO)
        begin
            y_sat = bqf_pkg::sample_t'(SAT_LO[bqf_pkg::SAMPLE_BITS-1:0]);
        end
        else
        begin
            y_sat = bqf_pkg::sample_t'(acc_shift[bqf_pkg::SAMPLE_BITS-1:0]);
        end
    end

    // out-of-range channel passes the sample through untouched
    assign y_word = s3_ok_reg ? y_sat : s3_x_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_accept;
            end
            if (en1)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en2)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en3)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg  <= sample_in;
            s1_ch_reg <= channel;
            s1_be_reg <= block_end;
            s1_ok_reg <= ch_ok;
        end
        if (en1 && s1_valid_reg)
        begin
            for (int i = 0; i < 5; i++)
            begin
                s2_prod_reg[i] <= prod[i];
            end
            s2_x_reg  <= s1_x_reg;
            s2_x1_reg <= hist_rd.x1;
            s2_y1_reg <= hist_rd.y1;
            s2_ch_reg <= s1_ch_reg;
            s2_be_reg <= s1_be_reg;
            s2_ok_reg <= s1_ok_reg;
        end
        if (en2 && s2_valid_reg)
        begin
            s3_acc_reg <= acc_sum;
            s3_x_reg   <= s2_x_reg;
            s3_x1_reg  <= s2_x1_reg;
            s3_y1_reg  <= s2_y1_reg;
            s3_ch_reg  <= s2_ch_reg;
            s3_be_reg  <= s2_be_reg;
            s3_ok_reg  <= s2_ok_reg;
        end
        if (en3 && s3_valid_reg)
        begin
            sample_out_reg    <= y_word;
            channel_out_reg   <= s3_ch_reg;
            block_end_out_reg <= s3_be_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign channel_out   = channel_out_reg;
    assign block_end_out = block_end_out_reg;

endmodule

[hdl/bqf_hist_mem.sv]
// Per-channel history memory: synchronous read, one write port, reset-to-zero via written bits.
`timescale 1ns / 1ps

module bqf_hist_mem (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  bqf_pkg::chan_t rd_addr,
    output bqf_pkg::hist_t rd_data,
    input  logic           wr_en,
    input  bqf_pkg::chan_t wr_addr,
    input  bqf_pkg::hist_t wr_data
);

    bqf_pkg::hist_t                 mem_reg [bqf_pkg::CHANNELS];
    logic [bqf_pkg::CHANNELS-1:0]   written_reg;
    bqf_pkg::hist_t                 rd_data_reg;
    logic                           rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // entries never written read as zero history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

[hdl/bqf_port_checker.sv]
// Port-level assertions for the multichannel biquad filter, bound to the top level.
`timescale 1ns / 1ps
`include "multichannel_biquad_filter_macros.svh"

module bqf_port_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic [bqf_pkg::CH_BITS-1:0]            channel,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [bqf_pkg::SAMPLE_BITS-1:0] sample_out,
    input logic [bqf_pkg::CH_BITS-1:0]            channel_out,
    input logic                                   block_end_out
);

    `BQF_ASSERT_HOLD(a_out_hold, out_valid, out_stall, {sample_out, channel_out, block_end_out})
    `BQF_ASSERT_SAME_CH_WAIT(a_same_ch_wait1, 1)
    `BQF_ASSERT_SAME_CH_WAIT(a_same_ch_wait3, 3)

endmodule

bind multichannel_biquad_filter bqf_port_checker u_bqf_port_checker (.*);
